FILE: sv/spm_pkg.sv
// Package for the sparse polynomial multiplier: field widths, item kind codes,
// default parameter values and the control structs shared between modules.
// No dependencies.
package spm_pkg;

    // Default values for the top-level parameters.
    localparam int DEF_MAX_DEGREE = 15;
    localparam int DEF_COEF_WIDTH = 16;

    // Fixed widths of the input and result word fields.
    localparam int KIND_W     = 2;
    localparam int EXP_W      = 4;
    localparam int IN_COEF_W  = 16;
    localparam int TERM_EXP_W = 5;
    localparam int PROD_W     = 40;

    // Item kinds carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_ADD_FIRST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD_SECOND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MULTIPLY   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 2'd3;

    // Command to one coefficient store.
    typedef struct packed {
        logic add;
        logic clr;
    } t_store_cmd;

    // Status from the multiply-accumulate engine.
    typedef struct packed {
        logic done;
        logic found;
    } t_mac_stat;

endpackage

FILE: sv/spm_if.sv
// Handshake interfaces for the input word and the result word channels.
// Depends on spm_pkg for the field widths.
interface spm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [spm_pkg::KIND_W-1:0]           kind;
    logic [spm_pkg::EXP_W-1:0]            exponent;
    logic signed [spm_pkg::IN_COEF_W-1:0] coefficient;

    modport source (output valid, kind, exponent, coefficient, input ready);
    modport sink   (input valid, kind, exponent, coefficient, output ready);
endinterface

interface spm_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [spm_pkg::TERM_EXP_W-1:0]        term_exponent;
    logic signed [spm_pkg::PROD_W-1:0]     term_coefficient;
    logic                                  last;
    logic                                  is_zero;

    modport source (output valid, term_exponent, term_coefficient, last, is_zero,
                    input ready);
    modport sink   (input valid, term_exponent, term_coefficient, last, is_zero,
                    output ready);
endinterface

FILE: sv/spm_coef_store.sv
// Dense coefficient store of one input polynomial, indexed by exponent.
// Depends on spm_pkg; per-entry valid bits make a clear take effect at once.
module spm_coef_store #(
    parameter int MAX_DEGREE = spm_pkg::DEF_MAX_DEGREE,
    parameter int COEF_WIDTH = spm_pkg::DEF_COEF_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  spm_pkg::t_store_cmd                  i_cmd,
    input  logic [$clog2(MAX_DEGREE+1)-1:0]      i_addr,
    input  logic signed [spm_pkg::IN_COEF_W-1:0] i_coef,
    output logic signed [COEF_WIDTH-1:0]         o_data
);
    localparam int DEPTH = MAX_DEGREE + 1;

    logic [DEPTH-1:0]            r_vld;
    logic signed [COEF_WIDTH-1:0] r_entry [DEPTH];
    logic signed [COEF_WIDTH-1:0] n_entry;

    // An entry that was never written since the last clear reads as zero.
    assign o_data  = r_vld[i_addr] ? r_entry[i_addr] : '0;
    // The added term wraps to the store width.
    assign n_entry = o_data + COEF_WIDTH'(i_coef);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.clr) begin
            r_vld <= '0;
        end else if (i_cmd.add) begin
            r_vld[i_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_entry[i_addr] <= n_entry;
        end
    end

endmodule

FILE: sv/spm_mac_engine.sv
// Shared multiply-accumulate unit with its sequencer: walks every product
// exponent in ascending order and sums the matching coefficient pairs.
// Depends on spm_pkg; reads both coefficient stores, writes the product memory.
module spm_mac_engine #(
    parameter int MAX_DEGREE = spm_pkg::DEF_MAX_DEGREE,
    parameter int COEF_WIDTH = spm_pkg::DEF_COEF_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic [$clog2(MAX_DEGREE+1)-1:0]       o_addr_a,
    output logic [$clog2(MAX_DEGREE+1)-1:0]       o_addr_b,
    input  logic signed [COEF_WIDTH-1:0]          i_data_a,
    input  logic signed [COEF_WIDTH-1:0]          i_data_b,
    output logic                                  o_wr_en,
    output logic [$clog2(2*MAX_DEGREE+1)-1:0]     o_wr_addr,
    output logic signed [spm_pkg::PROD_W-1:0]     o_wr_data,
    output logic [$clog2(2*MAX_DEGREE+1)-1:0]     o_low,
    output spm_pkg::t_mac_stat                    o_stat
);
    localparam int AW    = $clog2(MAX_DEGREE + 1);
    localparam int KW    = $clog2(2 * MAX_DEGREE + 1);
    localparam int MUL_W = 2 * COEF_WIDTH;
    localparam int EXT_W = (MUL_W > spm_pkg::PROD_W) ? MUL_W : spm_pkg::PROD_W;
    localparam logic [KW-1:0] K_D    = KW'(MAX_DEGREE);
    localparam logic [KW-1:0] K_LAST = KW'(2 * MAX_DEGREE);
    localparam logic [AW-1:0] I_MAX  = AW'(MAX_DEGREE);

    // Issue counters.
    logic          r_issuing, n_issuing;
    logic [KW-1:0] r_k, n_k;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] w_lo, w_hi, w_lo_nx;
    logic [KW-1:0] w_k_nx;
    logic          w_first, w_end;

    // Operand stage.
    logic                         r_a_vld, r_a_first, r_a_end;
    logic [KW-1:0]                r_a_k;
    logic signed [COEF_WIDTH-1:0] r_a_op, r_b_op;

    // Multiply stage.
    logic                               r_m_vld, r_m_first, r_m_end;
    logic [KW-1:0]                      r_m_k;
    logic signed [spm_pkg::PROD_W-1:0]  r_mul;
    logic signed [MUL_W-1:0]            w_mul;
    logic signed [EXT_W-1:0]            w_mul_ext;

    // Accumulate stage.
    logic signed [spm_pkg::PROD_W-1:0]  r_acc, n_sum;
    logic                               r_found, r_done;
    logic [KW-1:0]                      r_low;

    // Range of first-operand exponents that contribute to product exponent k.
    assign w_lo    = (r_k > K_D) ? AW'(r_k - K_D) : '0;
    assign w_hi    = (r_k < K_D) ? AW'(r_k) : I_MAX;
    assign w_k_nx  = r_k + KW'(1);
    assign w_lo_nx = (w_k_nx > K_D) ? AW'(w_k_nx - K_D) : '0;
    assign w_first = (r_i == w_lo);
    assign w_end   = (r_i == w_hi);

    assign o_addr_a = r_i;
    assign o_addr_b = AW'(r_k - KW'(r_i));

    // Next pair to issue.
    always_comb begin
        n_issuing = r_issuing;
        n_k       = r_k;
        n_i       = r_i;
        if (i_start) begin
            n_issuing = 1'b1;
            n_k       = '0;
            n_i       = '0;
        end else if (r_issuing) begin
            if (w_end) begin
                if (r_k == K_LAST) begin
                    n_issuing = 1'b0;
                end else begin
                    n_k = w_k_nx;
                    n_i = w_lo_nx;
                end
            end else begin
                n_i = r_i + AW'(1);
            end
        end
    end

    // Signed product, wrapped to the product width.
    assign w_mul     = r_a_op * r_b_op;
    assign w_mul_ext = EXT_W'(w_mul);

    // Running sum of the current product exponent.
    assign n_sum     = (r_m_first ? '0 : r_acc) + r_mul;
    assign o_wr_en   = r_m_vld && r_m_end;
    assign o_wr_addr = r_m_k;
    assign o_wr_data = n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
            r_a_vld   <= 1'b0;
            r_m_vld   <= 1'b0;
            r_found   <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_issuing <= n_issuing;
            r_a_vld   <= r_issuing;
            r_m_vld   <= r_a_vld;
            r_done    <= o_wr_en && (r_m_k == K_LAST);
            if (i_start) begin
                r_found <= 1'b0;
            end else if (o_wr_en && (n_sum != '0) && !r_found) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_i       <= n_i;
        r_a_first <= w_first;
        r_a_end   <= w_end;
        r_a_k     <= r_k;
        r_a_op    <= i_data_a;
        r_b_op    <= i_data_b;
        r_m_first <= r_a_first;
        r_m_end   <= r_a_end;
        r_m_k     <= r_a_k;
        r_mul     <= w_mul_ext[spm_pkg::PROD_W-1:0];
        if (r_m_vld) begin
            r_acc <= n_sum;
        end
        // Lowest nonzero exponent, the first one met in ascending order.
        if (o_wr_en && (n_sum != '0) && !r_found) begin
            r_low <= r_m_k;
        end
    end

    assign o_low        = r_low;
    assign o_stat.done  = r_done;
    assign o_stat.found = r_found;

endmodule

FILE: sv/spm_term_emitter.sv
// Product memory and the scanner that sends nonzero product terms out in
// descending exponent order. Depends on spm_pkg and spm_if.
module spm_term_emitter #(
    parameter int MAX_DEGREE = spm_pkg::DEF_MAX_DEGREE
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [$clog2(2*MAX_DEGREE+1)-1:0]  i_wr_addr,
    input  logic signed [spm_pkg::PROD_W-1:0]  i_wr_data,
    input  logic [$clog2(2*MAX_DEGREE+1)-1:0]  i_low,
    input  spm_pkg::t_mac_stat                 i_stat,
    output logic                               o_done,
    spm_out_if.source                          o_out
);
    localparam int KW   = $clog2(2 * MAX_DEGREE + 1);
    localparam int PLEN = 2 * MAX_DEGREE + 1;
    localparam logic [KW-1:0] K_LAST = KW'(2 * MAX_DEGREE);

    localparam logic [1:0] EM_IDLE  = 2'd0;
    localparam logic [1:0] EM_READ  = 2'd1;
    localparam logic [1:0] EM_CHECK = 2'd2;
    localparam logic [1:0] EM_OUT   = 2'd3;

    logic signed [spm_pkg::PROD_W-1:0] r_mem [PLEN];
    logic signed [spm_pkg::PROD_W-1:0] r_rdata;
    logic [1:0]                        r_state, n_state;
    logic [KW-1:0]                     r_k, n_k;
    logic                              w_load, w_accept;

    logic [spm_pkg::TERM_EXP_W-1:0]    r_out_exp, n_out_exp;
    logic signed [spm_pkg::PROD_W-1:0] r_out_coef, n_out_coef;
    logic                              r_out_last, n_out_last;
    logic                              r_out_zero, n_out_zero;

    // Product memory: written by the accumulator, read with a registered port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= r_mem[r_k];
    end

    assign w_accept = o_out.valid && o_out.ready;
    assign o_done   = w_accept && r_out_last;

    // Scan sequencer.
    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        w_load     = 1'b0;
        n_out_exp  = r_out_exp;
        n_out_coef = r_out_coef;
        n_out_last = r_out_last;
        n_out_zero = r_out_zero;
        unique case (r_state)
            EM_IDLE: begin
                if (i_stat.done) begin
                    if (i_stat.found) begin
                        n_k     = K_LAST;
                        n_state = EM_READ;
                    end else begin
                        // Whole product is zero: one word flagged as such.
                        w_load     = 1'b1;
                        n_out_exp  = '0;
                        n_out_coef = '0;
                        n_out_last = 1'b1;
                        n_out_zero = 1'b1;
                        n_state    = EM_OUT;
                    end
                end
            end
            EM_READ: begin
                n_state = EM_CHECK;
            end
            EM_CHECK: begin
                if (r_rdata != '0) begin
                    w_load     = 1'b1;
                    n_out_exp  = spm_pkg::TERM_EXP_W'(r_k);
                    n_out_coef = r_rdata;
                    n_out_last = (r_k == i_low);
                    n_out_zero = 1'b0;
                    n_state    = EM_OUT;
                end else begin
                    n_k     = r_k - KW'(1);
                    n_state = EM_READ;
                end
            end
            EM_OUT: begin
                if (w_accept) begin
                    if (r_out_last) begin
                        n_state = EM_IDLE;
                    end else begin
                        n_k     = r_k - KW'(1);
                        n_state = EM_READ;
                    end
                end
            end
            default: begin
                n_state = EM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= EM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        if (w_load) begin
            r_out_exp  <= n_out_exp;
            r_out_coef <= n_out_coef;
            r_out_last <= n_out_last;
            r_out_zero <= n_out_zero;
        end
    end

    assign o_out.valid            = (r_state == EM_OUT);
    assign o_out.term_exponent    = r_out_exp;
    assign o_out.term_coefficient = r_out_coef;
    assign o_out.last             = r_out_last;
    assign o_out.is_zero          = r_out_zero;

endmodule

FILE: sv/sparse_polynomial_multiplier_unit.sv
// Polynomial multiplier over two dense coefficient stores of MAX_DEGREE+1
// entries each. Add-term and clear words update the stores and produce nothing.
// A multiply word keeps the input channel busy until its last result word
// is taken: the shared multiply-accumulate unit issues one coefficient pair
// per cycle, (MAX_DEGREE+1)^2 pairs in all, through its operand, multiply and
// accumulate stages, then the scanner walks the product memory from exponent
// 2*MAX_DEGREE down to the lowest nonzero term, reading and checking each
// exponent and sending each nonzero term as a word that waits until taken.
// Depends on spm_pkg, spm_if, spm_coef_store, spm_mac_engine, spm_term_emitter.
module sparse_polynomial_multiplier_unit #(
    parameter int MAX_DEGREE = spm_pkg::DEF_MAX_DEGREE,
    parameter int COEF_WIDTH = spm_pkg::DEF_COEF_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spm_in_if.sink     i_in,
    spm_out_if.source  o_out
);
    localparam int AW = $clog2(MAX_DEGREE + 1);
    localparam int KW = $clog2(2 * MAX_DEGREE + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                   r_state, n_state;
    logic                         w_accept, w_exp_ok, w_start, w_emit_done;
    spm_pkg::t_store_cmd          w_cmd_a, w_cmd_b;
    logic [AW-1:0]                w_addr_a, w_addr_b, w_mac_a, w_mac_b;
    logic signed [COEF_WIDTH-1:0] w_data_a, w_data_b;
    logic                         w_wr_en;
    logic [KW-1:0]                w_wr_addr, w_low;
    logic signed [spm_pkg::PROD_W-1:0] w_wr_data;
    spm_pkg::t_mac_stat           w_stat;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_exp_ok   = (32'(i_in.exponent) <= 32'(MAX_DEGREE));

    // Decode of an accepted input word.
    always_comb begin
        w_cmd_a = '0;
        w_cmd_b = '0;
        w_start = 1'b0;
        if (w_accept) begin
            unique case (i_in.kind)
                spm_pkg::KIND_ADD_FIRST:  w_cmd_a.add = w_exp_ok;
                spm_pkg::KIND_ADD_SECOND: w_cmd_b.add = w_exp_ok;
                spm_pkg::KIND_MULTIPLY:   w_start     = 1'b1;
                spm_pkg::KIND_CLEAR: begin
                    w_cmd_a.clr = 1'b1;
                    w_cmd_b.clr = 1'b1;
                end
            endcase
        end
    end

    // Store addresses come from the input word, or from the sequencer.
    assign w_addr_a = (r_state == ST_MAC) ? w_mac_a : AW'(i_in.exponent);
    assign w_addr_b = (r_state == ST_MAC) ? w_mac_b : AW'(i_in.exponent);

    // Top-level sequencing of a multiply word.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_start)     n_state = ST_MAC;
            ST_MAC:  if (w_stat.done) n_state = ST_EMIT;
            ST_EMIT: if (w_emit_done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    spm_coef_store #(
        .MAX_DEGREE (MAX_DEGREE),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_a),
        .i_addr  (w_addr_a),
        .i_coef  (i_in.coefficient),
        .o_data  (w_data_a)
    );

    spm_coef_store #(
        .MAX_DEGREE (MAX_DEGREE),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_b),
        .i_addr  (w_addr_b),
        .i_coef  (i_in.coefficient),
        .o_data  (w_data_b)
    );

    spm_mac_engine #(
        .MAX_DEGREE (MAX_DEGREE),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .o_addr_a  (w_mac_a),
        .o_addr_b  (w_mac_b),
        .i_data_a  (w_data_a),
        .i_data_b  (w_data_b),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_low     (w_low),
        .o_stat    (w_stat)
    );

    spm_term_emitter #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_low     (w_low),
        .i_stat    (w_stat),
        .o_done    (w_emit_done),
        .o_out     (o_out)
    );

endmodule

FILE: dv/sparse_polynomial_multiplier_unit_tb.sv
// Self-checking testbench for sparse_polynomial_multiplier_unit: drives add, clear and
// multiply words, predicts every product term in a local model and checks each result word.
// Depends on spm_pkg, spm_if and the sparse_polynomial_multiplier_unit RTL.
module sparse_polynomial_multiplier_unit_tb;

    localparam int MAX_DEG       = spm_pkg::DEF_MAX_DEGREE;
    localparam int STORE_DEPTH   = MAX_DEG + 1;
    localparam int PRODUCT_DEPTH = 2 * MAX_DEG + 1;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 400;

    // One expected or observed product term.
    typedef struct packed {
        logic [spm_pkg::TERM_EXP_W-1:0]    exp;
        logic signed [spm_pkg::PROD_W-1:0] coef;
        logic                              last;
        logic                              is_zero;
    } t_term;

    logic i_clk;
    logic i_rst_n;

    spm_in_if  in_if ();
    spm_out_if out_if ();

    sparse_polynomial_multiplier_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Local copy of the two coefficient stores and the queue of pending product terms.
    logic signed [spm_pkg::IN_COEF_W-1:0] poly_first  [STORE_DEPTH];
    logic signed [spm_pkg::IN_COEF_W-1:0] poly_second [STORE_DEPTH];
    t_term                                product_terms_q [$];

    int mismatch_count = 0;
    int stall_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Clock generation.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Result ready, stalled at random at the falling edge.
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Convolve the two stores and queue the nonzero terms, highest exponent first.
    function automatic void multiply_stores();
        logic signed [spm_pkg::PROD_W-1:0] prod [PRODUCT_DEPTH];
        logic signed [spm_pkg::PROD_W-1:0] a_ext;
        logic signed [spm_pkg::PROD_W-1:0] b_ext;
        t_term                             t;
        int                                lowest;
        lowest = -1;
        foreach (prod[k]) prod[k] = '0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            a_ext = poly_first[i];
            for (int j = 0; j < STORE_DEPTH; j++) begin
                b_ext = poly_second[j];
                prod[i + j] = prod[i + j] + a_ext * b_ext;
            end
        end
        for (int k = PRODUCT_DEPTH - 1; k >= 0; k--) begin
            if (prod[k] != 0) lowest = k;
        end
        if (lowest < 0) begin
            t = '{exp: '0, coef: '0, last: 1'b1, is_zero: 1'b1};
            product_terms_q.push_back(t);
        end else begin
            for (int k = PRODUCT_DEPTH - 1; k >= 0; k--) begin
                if (prod[k] != 0) begin
                    t = '{exp: spm_pkg::TERM_EXP_W'(k), coef: prod[k], last: (k == lowest),
                          is_zero: 1'b0};
                    product_terms_q.push_back(t);
                end
            end
        end
    endfunction

    // Update the local stores for one accepted input word.
    function automatic void predict_word(logic [spm_pkg::KIND_W-1:0] kind,
                                         logic [spm_pkg::EXP_W-1:0] exponent,
                                         logic signed [spm_pkg::IN_COEF_W-1:0] coefficient);
        case (kind)
            spm_pkg::KIND_ADD_FIRST: begin
                if (exponent <= MAX_DEG) poly_first[exponent] += coefficient;
            end
            spm_pkg::KIND_ADD_SECOND: begin
                if (exponent <= MAX_DEG) poly_second[exponent] += coefficient;
            end
            spm_pkg::KIND_CLEAR: begin
                foreach (poly_first[k]) poly_first[k] = '0;
                foreach (poly_second[k]) poly_second[k] = '0;
            end
            default: begin
                multiply_stores();
            end
        endcase
    endfunction

    // Monitor: predict on input acceptance, then check any accepted result word.
    always @(posedge i_clk) begin
        t_term got;
        t_term want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                predict_word(in_if.kind, in_if.exponent, in_if.coefficient);
            end
            if (out_if.valid && out_if.ready) begin
                got = '{exp: out_if.term_exponent, coef: out_if.term_coefficient,
                        last: out_if.last, is_zero: out_if.is_zero};
                if (product_terms_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result word: exp %0d coef %0d last %0b zero %0b",
                                 got.exp, got.coef, got.last, got.is_zero);
                    end
                end else begin
                    want = product_terms_q.pop_front();
                    if (got.exp !== want.exp || got.coef !== want.coef ||
                        got.last !== want.last || got.is_zero !== want.is_zero) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display({"term mismatch: expected exp %0d coef %0d",
                                      " last %0b zero %0b"},
                                     want.exp, want.coef, want.last, want.is_zero);
                            $display({"               got      exp %0d coef %0d",
                                      " last %0b zero %0b"},
                                     got.exp, got.coef, got.last, got.is_zero);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Send one input word, with a random idle gap in front, and wait until it is taken.
    task automatic send_word(input logic [spm_pkg::KIND_W-1:0] kind,
                             input logic [spm_pkg::EXP_W-1:0] exponent,
                             input logic signed [spm_pkg::IN_COEF_W-1:0] coefficient);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.kind        <= kind;
        in_if.exponent    <= exponent;
        in_if.coefficient <= coefficient;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // Lower valid once the stream pauses.
    task automatic stop_sending();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    // Block until every predicted term has been taken.
    task automatic wait_results_drained();
        while (product_terms_q.size() != 0) @(negedge i_clk);
    endtask

    // Random coefficient, weighted toward the extremes.
    function automatic logic signed [spm_pkg::IN_COEF_W-1:0] pick_coef();
        case ($urandom_range(7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0001;
            3:       return -16'sh0001;
            default: return spm_pkg::IN_COEF_W'($urandom);
        endcase
    endfunction

    // Multiply and clear with random filler in the fields that they ignore.
    task automatic send_multiply();
        send_word(spm_pkg::KIND_MULTIPLY, spm_pkg::EXP_W'($urandom),
                  spm_pkg::IN_COEF_W'($urandom));
    endtask

    task automatic send_clear();
        send_word(spm_pkg::KIND_CLEAR, spm_pkg::EXP_W'($urandom),
                  spm_pkg::IN_COEF_W'($urandom));
    endtask

    // Empty stores, add wrap, extreme coefficients, a cancelled middle term and clear.
    task automatic test_directed_cases();
        send_multiply();
        send_word(spm_pkg::KIND_ADD_FIRST, 4'd0, 16'sh7FFF);
        send_word(spm_pkg::KIND_ADD_FIRST, 4'd0, 16'sh7FFF);
        send_word(spm_pkg::KIND_ADD_FIRST, 4'd15, 16'sh8000);
        send_word(spm_pkg::KIND_ADD_SECOND, 4'd15, 16'sh8000);
        send_word(spm_pkg::KIND_ADD_SECOND, 4'd0, 16'sh0001);
        send_multiply();
        send_word(spm_pkg::KIND_ADD_SECOND, 4'd0, -16'sh0001);
        send_multiply();
        send_clear();
        send_word(spm_pkg::KIND_ADD_FIRST, 4'd1, 16'sh0001);
        send_word(spm_pkg::KIND_ADD_FIRST, 4'd0, 16'sh0001);
        send_word(spm_pkg::KIND_ADD_SECOND, 4'd1, 16'sh0001);
        send_word(spm_pkg::KIND_ADD_SECOND, 4'd0, -16'sh0001);
        send_multiply();
        send_clear();
        send_multiply();
        send_word(spm_pkg::KIND_ADD_FIRST, 4'd5, 16'sh0000);
        send_word(spm_pkg::KIND_ADD_SECOND, 4'd10, 16'sh0000);
        send_multiply();
        stop_sending();
    endtask

    // Both stores filled at every exponent with the most negative value: all 31 terms.
    task automatic test_full_degree();
        send_clear();
        for (int e = 0; e < STORE_DEPTH; e++) begin
            send_word(spm_pkg::KIND_ADD_FIRST, spm_pkg::EXP_W'(e), 16'sh8000);
            send_word(spm_pkg::KIND_ADD_SECOND, spm_pkg::EXP_W'(e), 16'sh8000);
        end
        send_multiply();
        stop_sending();
    endtask

    // Mostly well-formed load and multiply runs, with some words of random kind between them.
    task automatic test_random_sequences(input int n_words);
        int sent;
        int n_adds;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(9) < 8) begin
                if ($urandom_range(1)) begin
                    send_clear();
                    sent++;
                end
                n_adds = ($urandom_range(7) == 0) ? 16 : $urandom_range(1, 5);
                for (int k = 0; k < n_adds; k++) begin
                    send_word(spm_pkg::KIND_ADD_FIRST, spm_pkg::EXP_W'($urandom), pick_coef());
                    send_word(spm_pkg::KIND_ADD_SECOND, spm_pkg::EXP_W'($urandom), pick_coef());
                    sent += 2;
                end
                send_multiply();
                sent++;
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_word(spm_pkg::KIND_W'($urandom), spm_pkg::EXP_W'($urandom),
                              pick_coef());
                    sent++;
                end
            end
        end
        stop_sending();
    endtask

    // The sender holds off until every result has arrived, then multiplies the same stores.
    task automatic test_pause_for_results();
        send_word(spm_pkg::KIND_ADD_FIRST, spm_pkg::EXP_W'($urandom), pick_coef());
        send_word(spm_pkg::KIND_ADD_SECOND, spm_pkg::EXP_W'($urandom), pick_coef());
        send_multiply();
        stop_sending();
        wait_results_drained();
        send_multiply();
        stop_sending();
    endtask

    // Test sequence.
    initial begin
        foreach (poly_first[k]) poly_first[k] = '0;
        foreach (poly_second[k]) poly_second[k] = '0;
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.kind         = spm_pkg::KIND_ADD_FIRST;
        in_if.exponent     = '0;
        in_if.coefficient  = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_directed_cases();
        test_full_degree();
        test_random_sequences(40);

        send_idle_pct  = 45;
        recv_stall_pct = 0;
        test_random_sequences(40);
        test_pause_for_results();

        send_idle_pct  = 0;
        recv_stall_pct = 45;
        test_random_sequences(40);

        send_idle_pct  = 16;
        recv_stall_pct = 16;
        test_random_sequences(40);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && product_terms_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
